>>> src/aac_section_data_parser_macros.svh
// ----------------------------------------------------------------------------
// aac section data parser assertion macros
// shared property wrappers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef AAC_SECTION_DATA_PARSER_MACROS_SVH
`define AAC_SECTION_DATA_PARSER_MACROS_SVH

`ifndef SYNTHESIS

`define AACSDP_ASSERT_IMPLY(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("aacsdp: same-cycle check failed");

`define AACSDP_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("aacsdp: next-cycle check failed");

`else

`define AACSDP_ASSERT_IMPLY(name, cond, prop)

`define AACSDP_ASSERT_NEXT(name, cond, prop)

`endif

`endif

>>> src/aacsdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aacsdp_pkg
// shared types, codes and helpers of the section data parser
// ----------------------------------------------------------------------------
package aacsdp_pkg;

    localparam int GROUPS_DEF      = 8;
    localparam int BANDS_DEF       = 64;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int GROUP_SLOTS     = 8;

    localparam int CB_W        = 4;
    localparam int LEN_W_LONG  = 5;
    localparam int LEN_W_SHORT = 3;

    localparam logic [1:0] REQ_BIT   = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    localparam logic [1:0] KIND_SECTION = 2'd0;
    localparam logic [1:0] KIND_QUERY   = 2'd1;
    localparam logic [1:0] KIND_FINISH  = 2'd2;

    localparam logic [1:0] CFG_SHORT_WINDOWS = 2'd0;
    localparam logic [1:0] CFG_WINDOW_GROUPS = 2'd1;
    localparam logic [1:0] CFG_MAX_BANDS     = 2'd2;

    localparam logic [3:0] CB_NOISE     = 4'd13;
    localparam logic [3:0] CB_INTENS_OP = 4'd14;
    localparam logic [3:0] CB_INTENS_IP = 4'd15;

    localparam logic [6:0] LEN_SUM_MAX = 7'd127;
    localparam logic [6:0] SEC_CNT_MAX = 7'd127;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_QUERY   = 2'd1,
        OP_SECTION = 2'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] group;
        logic [5:0] section_index;
        logic [3:0] codebook;
        logic [5:0] start_band;
        logic [6:0] end_band;
        logic       group_done;
        logic [6:0] section_count;
        logic       overflow;
        logic       last;
    } cmd_t;

    function automatic logic signed [1:0] intensity_of(input logic [3:0] cb);
        logic signed [1:0] s;
        begin
            s = 2'sd0;
            if (cb == CB_INTENS_IP)
            begin
                s = 2'sd1;
            end
            else if (cb == CB_INTENS_OP)
            begin
                s = -2'sd1;
            end
            return s;
        end
    endfunction

    function automatic logic noise_of(input logic [3:0] cb);
        return (cb == CB_NOISE);
    endfunction

endpackage

>>> src/aacsdp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aacsdp_front
// bit parser: takes beats, tracks section fields, queues commands
// ----------------------------------------------------------------------------
module aacsdp_front #(
    parameter int GROUPS = aacsdp_pkg::GROUPS_DEF,
    parameter int BANDS  = aacsdp_pkg::BANDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [5:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic               stream_bit,
    input  logic [2:0]         query_group,
    input  logic [5:0]         query_band,
    input  logic               queue_full,
    output logic               push,
    output aacsdp_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_CODEBOOK = 3'b010,
        PH_LENGTH   = 3'b100
    } phase_t;

    logic       short_reg;
    logic [3:0] groups_cfg_reg;
    logic [5:0] bands_cfg_reg;

    phase_t     phase_reg,   phase_next;
    logic [2:0] group_reg,   group_next;
    logic [6:0] band_reg,    band_next;
    logic [6:0] sec_reg,     sec_next;
    logic [4:0] shift_reg,   shift_next;
    logic [2:0] bits_reg,    bits_next;
    logic [3:0] held_cb_reg, held_cb_next;
    logic [6:0] len_reg,     len_next;

    logic       accept;
    logic [3:0] group_limit;
    logic [6:0] band_limit;
    logic [4:0] shift_in;
    logic [2:0] bits_in;
    logic [2:0] field_w;
    logic [4:0] esc;
    logic [4:0] len_val;
    logic [7:0] sum_wide;
    logic [6:0] sum_sat;
    logic [7:0] end_wide;
    logic       ovf;
    logic [6:0] end_band;
    logic [6:0] sec_inc;
    logic       done;
    logic       last;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    assign group_limit = (groups_cfg_reg > 4'(GROUPS)) ? 4'(GROUPS) : groups_cfg_reg;
    assign band_limit  = ({1'b0, bands_cfg_reg} > 7'(BANDS)) ? 7'(BANDS)
                                                              : {1'b0, bands_cfg_reg};

    assign shift_in = {shift_reg[3:0], stream_bit};
    assign bits_in  = bits_reg + 3'd1;
    assign field_w  = short_reg ? 3'(aacsdp_pkg::LEN_W_SHORT) : 3'(aacsdp_pkg::LEN_W_LONG);
    assign esc      = short_reg ? 5'd7 : 5'd31;
    assign len_val  = short_reg ? {2'b00, shift_in[2:0]} : shift_in;
    assign sum_wide = {1'b0, len_reg} + {3'b000, len_val};
    assign sum_sat  = (sum_wide > {1'b0, aacsdp_pkg::LEN_SUM_MAX}) ? aacsdp_pkg::LEN_SUM_MAX
                                                                  : sum_wide[6:0];
    assign end_wide = {1'b0, band_reg} + {1'b0, sum_sat};
    assign ovf      = end_wide > 8'(BANDS);
    assign end_band = ovf ? 7'(BANDS) : end_wide[6:0];
    assign sec_inc  = (sec_reg < aacsdp_pkg::SEC_CNT_MAX) ? sec_reg + 7'd1 : sec_reg;
    assign done     = end_band >= band_limit;
    assign last     = done && (({1'b0, group_reg} + 4'd1) >= group_limit);

    always_comb
    begin
        phase_next   = phase_reg;
        group_next   = group_reg;
        band_next    = band_reg;
        sec_next     = sec_reg;
        shift_next   = shift_reg;
        bits_next    = bits_reg;
        held_cb_next = held_cb_reg;
        len_next     = len_reg;
        push         = 1'b0;
        cmd          = '0;
        cmd.op       = aacsdp_pkg::OP_START;

        if (accept)
        begin
            unique case (req_type)
                aacsdp_pkg::REQ_START:
                begin
                    group_next   = '0;
                    band_next    = '0;
                    sec_next     = '0;
                    shift_next   = '0;
                    bits_next    = '0;
                    held_cb_next = '0;
                    len_next     = '0;
                    push         = 1'b1;
                    cmd.op       = aacsdp_pkg::OP_START;
                    cmd.last     = (band_limit == 7'd0) || (group_limit == 4'd0);
                    phase_next   = cmd.last ? PH_IDLE : PH_CODEBOOK;
                end
                aacsdp_pkg::REQ_QUERY:
                begin
                    push           = 1'b1;
                    cmd.op         = aacsdp_pkg::OP_QUERY;
                    cmd.group      = query_group;
                    cmd.start_band = query_band;
                end
                aacsdp_pkg::REQ_BIT:
                begin
                    if (phase_reg == PH_CODEBOOK)
                    begin
                        shift_next = shift_in;
                        bits_next  = bits_in;
                        if (bits_in >= 3'(aacsdp_pkg::CB_W))
                        begin
                            held_cb_next = shift_in[3:0];
                            shift_next   = '0;
                            bits_next    = '0;
                            len_next     = '0;
                            phase_next   = PH_LENGTH;
                        end
                    end
                    else if (phase_reg == PH_LENGTH)
                    begin
                        shift_next = shift_in;
                        bits_next  = bits_in;
                        if (bits_in >= field_w)
                        begin
                            shift_next = '0;
                            bits_next  = '0;
                            if (len_val == esc)
                            begin
                                len_next = sum_sat;
                            end
                            else
                            begin
                                len_next          = '0;
                                push              = 1'b1;
                                cmd.op            = aacsdp_pkg::OP_SECTION;
                                cmd.group         = group_reg;
                                cmd.section_index = 6'(sec_inc - 7'd1);
                                cmd.codebook      = held_cb_reg;
                                cmd.start_band    = band_reg[5:0];
                                cmd.end_band      = end_band;
                                cmd.group_done    = done;
                                cmd.section_count = done ? sec_inc : 7'd0;
                                cmd.overflow      = ovf;
                                cmd.last          = last;
                                band_next         = end_band;
                                sec_next          = sec_inc;
                                if (last)
                                begin
                                    phase_next = PH_IDLE;
                                end
                                else if (done)
                                begin
                                    group_next = group_reg + 3'd1;
                                    band_next  = '0;
                                    sec_next   = '0;
                                    phase_next = PH_CODEBOOK;
                                end
                                else
                                begin
                                    phase_next = PH_CODEBOOK;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg      <= 1'b0;
            groups_cfg_reg <= 4'd1;
            bands_cfg_reg  <= 6'd0;
            phase_reg      <= PH_IDLE;
            group_reg      <= '0;
            band_reg       <= '0;
            sec_reg        <= '0;
            shift_reg      <= '0;
            bits_reg       <= '0;
            held_cb_reg    <= '0;
            len_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    aacsdp_pkg::CFG_SHORT_WINDOWS: short_reg      <= cfg_data[0];
                    aacsdp_pkg::CFG_WINDOW_GROUPS: groups_cfg_reg <= cfg_data[3:0];
                    aacsdp_pkg::CFG_MAX_BANDS:     bands_cfg_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            phase_reg   <= phase_next;
            group_reg   <= group_next;
            band_reg    <= band_next;
            sec_reg     <= sec_next;
            shift_reg   <= shift_next;
            bits_reg    <= bits_next;
            held_cb_reg <= held_cb_next;
            len_reg     <= len_next;
        end
    end

endmodule

>>> src/aacsdp_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aacsdp_cmd_fifo
// short command queue between the bit parser and the table engine
// ----------------------------------------------------------------------------
module aacsdp_cmd_fifo #(
    parameter int DEPTH = aacsdp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  aacsdp_pkg::cmd_t push_cmd,
    input  logic             pop,
    output aacsdp_pkg::cmd_t head,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aacsdp_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   cnt_reg,  cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = slot_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

>>> src/aacsdp_back.sv
`timescale 1ns / 1ps
`include "aac_section_data_parser_macros.svh"
// ----------------------------------------------------------------------------
// aacsdp_back
// table engine: fills the band table, answers queries, drives result beats
// ----------------------------------------------------------------------------
module aacsdp_back #(
    parameter int GROUPS = aacsdp_pkg::GROUPS_DEF,
    parameter int BANDS  = aacsdp_pkg::BANDS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  aacsdp_pkg::cmd_t head,
    input  logic             empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    localparam int DEPTH  = GROUPS * BANDS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_FILL  = 4'b0010,
        B_QUERY = 4'b0100,
        B_EMIT  = 4'b1000
    } bstate_t;

    bstate_t          state_reg, state_next;
    aacsdp_pkg::cmd_t cmd_reg,   cmd_next;
    logic [6:0]       band_reg,  band_next;
    logic             hit_reg,   hit_next;
    logic [6:0]       fill_reg [aacsdp_pkg::GROUP_SLOTS];

    logic [3:0]       mem [DEPTH];
    logic [3:0]       rd_data_reg;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic             wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic             out_free;
    logic             emit;
    logic             fill_clear;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [39:0]      data_reg;
    logic [1:0]       user_reg;
    logic             last_reg;

    logic             head_hit;
    logic [1:0]       r_kind;
    logic [2:0]       r_group;
    logic [5:0]       r_sidx;
    logic [3:0]       r_cb;
    logic [5:0]       r_start;
    logic [6:0]       r_end;
    logic             r_done;
    logic [6:0]       r_count;
    logic             r_ovf;

    assign out_free = !m_tvalid_reg || m_tready;
    assign head_hit = ({1'b0, head.group} < 4'(GROUPS))
                   && ({1'b0, head.start_band} < 7'(BANDS))
                   && ({1'b0, head.start_band} < fill_reg[head.group]);
    assign rd_addr  = ADDR_W'(int'(head.group) * BANDS + int'(head.start_band));
    assign wr_addr  = ADDR_W'(int'(cmd_reg.group) * BANDS + int'(band_reg));

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        band_next  = band_reg;
        hit_next   = hit_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        emit       = 1'b0;
        fill_clear = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    unique case (head.op)
                        aacsdp_pkg::OP_START:
                        begin
                            fill_clear = 1'b1;
                            state_next = head.last ? B_EMIT : B_IDLE;
                        end
                        aacsdp_pkg::OP_QUERY:
                        begin
                            hit_next   = head_hit;
                            rd_en      = head_hit;
                            state_next = B_QUERY;
                        end
                        aacsdp_pkg::OP_SECTION:
                        begin
                            band_next  = {1'b0, head.start_band};
                            state_next = ({1'b0, head.start_band} == head.end_band) ? B_EMIT
                                                                                    : B_FILL;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_FILL:
            begin
                wr_en     = 1'b1;
                band_next = band_reg + 7'd1;
                if (band_reg + 7'd1 == cmd_reg.end_band)
                begin
                    state_next = B_EMIT;
                end
            end
            B_QUERY:
            begin
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        r_kind  = aacsdp_pkg::KIND_FINISH;
        r_group = '0;
        r_sidx  = '0;
        r_cb    = '0;
        r_start = '0;
        r_end   = '0;
        r_done  = 1'b0;
        r_count = '0;
        r_ovf   = 1'b0;
        unique case (cmd_reg.op)
            aacsdp_pkg::OP_QUERY:
            begin
                r_kind  = aacsdp_pkg::KIND_QUERY;
                r_group = cmd_reg.group;
                r_cb    = hit_reg ? rd_data_reg : 4'd0;
                r_start = cmd_reg.start_band;
            end
            aacsdp_pkg::OP_SECTION:
            begin
                r_kind  = cmd_reg.last ? aacsdp_pkg::KIND_FINISH : aacsdp_pkg::KIND_SECTION;
                r_group = cmd_reg.group;
                r_sidx  = cmd_reg.section_index;
                r_cb    = cmd_reg.codebook;
                r_start = cmd_reg.start_band;
                r_end   = cmd_reg.end_band;
                r_done  = cmd_reg.group_done;
                r_count = cmd_reg.section_count;
                r_ovf   = cmd_reg.overflow;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (emit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // band table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd_reg.codebook;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_reg <= {3'b000, r_ovf, r_count, aacsdp_pkg::noise_of(r_cb),
                         aacsdp_pkg::intensity_of(r_cb), r_end, r_start, r_cb,
                         r_sidx, r_group};
            user_reg <= r_kind;
            last_reg <= r_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            cmd_reg      <= '0;
            band_reg     <= '0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < aacsdp_pkg::GROUP_SLOTS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            band_reg     <= band_next;
            hit_reg      <= hit_next;
            m_tvalid_reg <= m_tvalid_next;
            if (fill_clear)
            begin
                for (int i = 0; i < aacsdp_pkg::GROUP_SLOTS; i++)
                begin
                    fill_reg[i] <= '0;
                end
            end
            else if (emit && (cmd_reg.op == aacsdp_pkg::OP_SECTION))
            begin
                fill_reg[cmd_reg.group] <= cmd_reg.end_band;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    `AACSDP_ASSERT_IMPLY(a_fill_in_range, state_reg == B_FILL, (cmd_reg.op == aacsdp_pkg::OP_SECTION) && (band_reg < cmd_reg.end_band))
    `AACSDP_ASSERT_NEXT(a_query_to_emit, state_reg == B_QUERY, state_reg == B_EMIT)
    `AACSDP_ASSERT_IMPLY(a_pop_only_idle, pop, (state_reg == B_IDLE) && !empty)

endmodule

>>> src/aac_section_data_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_section_data_parser
// section data parser with band codebook table and query port
// ----------------------------------------------------------------------------
// A bit beat is taken every cycle while the four-entry command queue has room;
// the parser itself never stalls. Each section then occupies the table engine
// with one write per band and then issues its record; a query reads the table
// through a registered read before its result beat, and a start is handled in
// idle, going to emit only when it answers at once with a finish beat. The band
// table needs no clearing pass: per-group fill counts mark which bands hold
// data of the current parse, so a start is taken at once.
// ----------------------------------------------------------------------------
module aac_section_data_parser #(
    parameter int GROUPS      = aacsdp_pkg::GROUPS_DEF,
    parameter int BANDS       = aacsdp_pkg::BANDS_DEF,
    parameter int QUEUE_DEPTH = aacsdp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // stream_bit[0], query_group[3:1], query_band[9:4], zero[15:10]
    input  logic [15:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // group_index[2:0], section_index[8:3], codebook[12:9], start_band[18:13],
    // end_band[25:19], intensity_sign[27:26], noise_band[28],
    // section_count[35:29], overflow[36], zero[39:37]
    output logic [39:0] m_tdata,
    // result_kind[1:0]
    output logic [1:0]  m_tuser,
    // group_done
    output logic        m_tlast
);

    aacsdp_pkg::cmd_t push_cmd;
    aacsdp_pkg::cmd_t head;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    aacsdp_front #(
        .GROUPS (GROUPS),
        .BANDS  (BANDS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .req_type    (s_tuser),
        .stream_bit  (s_tdata[0]),
        .query_group (s_tdata[3:1]),
        .query_band  (s_tdata[9:4]),
        .queue_full  (full),
        .push        (push),
        .cmd         (push_cmd)
    );

    aacsdp_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    aacsdp_back #(
        .GROUPS (GROUPS),
        .BANDS  (BANDS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the section data parser: a directed table followed
// by randomly built section streams, each result checked against a fixed
// record or a predictor that tracks the parse state and band table beat by beat
// ----------------------------------------------------------------------------
module tb_top;

    localparam int GROUPS_N      = aacsdp_pkg::GROUPS_DEF;
    localparam int BANDS_N       = aacsdp_pkg::BANDS_DEF;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_REPORTS   = 10;
    localparam int DIR_SPLIT     = 5;
    localparam int DIR_ROWS      = 23;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_CODEBOOK = 3'b010,
        PH_LENGTH   = 3'b100
    } parse_phase_t;

    typedef struct packed {
        logic [1:0] req;
        logic       sbit;
        logic [2:0] qg;
        logic [5:0] qb;
    } parse_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [2:0]        group_idx;
        logic [5:0]        section_idx;
        logic [3:0]        codebook;
        logic [5:0]        start_band;
        logic [6:0]        end_band;
        logic signed [1:0] int_sign;
        logic              noise;
        logic              group_done;
        logic [6:0]        section_count;
        logic              overflow;
    } parse_record_t;

    typedef struct packed {
        parse_item_t   item;
        logic          fixed;
        logic          fixed_has;
        parse_record_t fixed_rec;
    } directed_row_t;

    localparam parse_record_t REC_NONE         = '0;
    localparam parse_record_t REC_EMPTY_FINISH = '{kind: aacsdp_pkg::KIND_FINISH,
                                                   default: '0};
    localparam parse_record_t REC_QUERY_ZERO   = '{kind: aacsdp_pkg::KIND_QUERY,
                                                   default: '0};
    localparam parse_record_t REC_QUERY_TOP    = '{kind: aacsdp_pkg::KIND_QUERY,
                                                   group_idx: 3'd7,
                                                   start_band: 6'd63, default: '0};

    // reset settings first, then short windows, two groups, one band
    localparam directed_row_t DIR_TAB [DIR_ROWS] = '{
        '{'{aacsdp_pkg::REQ_START,  1'b0, 3'd0, 6'd0},  1'b1, 1'b1, REC_EMPTY_FINISH},
        '{'{aacsdp_pkg::REQ_QUERY,  1'b0, 3'd7, 6'd63}, 1'b1, 1'b1, REC_QUERY_TOP},
        '{'{aacsdp_pkg::REQ_QUERY,  1'b1, 3'd0, 6'd0},  1'b1, 1'b1, REC_QUERY_ZERO},
        '{'{REQ_UNUSED,             1'b1, 3'd7, 6'd63}, 1'b1, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_BIT,    1'b1, 3'd5, 6'd42}, 1'b1, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_START,  1'b0, 3'd0, 6'd0},  1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_BIT,    1'b1, 3'd7, 6'd63}, 1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_BIT,    1'b1, 3'd0, 6'd0},  1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_BIT,    1'b1, 3'd2, 6'd21}, 1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_BIT,    1'b0, 3'd5, 6'd42}, 1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_BIT,    1'b0, 3'd0, 6'd0},  1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_BIT,    1'b0, 3'd7, 6'd63}, 1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_BIT,    1'b0, 3'd1, 6'd1},  1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_BIT,    1'b1, 3'd0, 6'd0},  1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_BIT,    1'b1, 3'd3, 6'd12}, 1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_BIT,    1'b1, 3'd4, 6'd51}, 1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_BIT,    1'b1, 3'd0, 6'd0},  1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_BIT,    1'b0, 3'd6, 6'd33}, 1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_BIT,    1'b0, 3'd0, 6'd0},  1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_BIT,    1'b1, 3'd7, 6'd63}, 1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_QUERY,  1'b0, 3'd0, 6'd0},  1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_START,  1'b1, 3'd7, 6'd63}, 1'b0, 1'b0, REC_NONE},
        '{'{aacsdp_pkg::REQ_QUERY,  1'b0, 3'd0, 6'd0},  1'b0, 1'b0, REC_NONE}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // register shadows and parse state of the predictor
    logic         reg_short;
    logic [3:0]   reg_groups;
    logic [5:0]   reg_bands;
    parse_phase_t phase;
    int           cur_grp;
    int           band_pos;
    int           sec_cnt;
    int           shift_bits;
    int           taken_bits;
    logic [3:0]   held_cb;
    int           len_sum;
    logic [3:0]   band_cb [0:GROUPS_N*BANDS_N-1];

    parse_record_t pending_records [$];
    parse_item_t   stim_q [$];
    int            work_items;
    int            mismatches;
    int unsigned   cycle_count;
    bit            calm_tx;
    bit            calm_rx;

    aac_section_data_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 32'd1;
    end

    initial
    begin : watchdog
        wait (cycle_count == CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    function automatic parse_record_t with_codebook(input parse_record_t r,
                                                   input logic [3:0] cb);
        parse_record_t o;
        begin
            o = r;
            o.codebook = cb;
            o.int_sign = (cb == aacsdp_pkg::CB_INTENS_IP) ? 2'sd1 :
                         (cb == aacsdp_pkg::CB_INTENS_OP) ? -2'sd1 : 2'sd0;
            o.noise    = (cb == aacsdp_pkg::CB_NOISE);
            return o;
        end
    endfunction

    function automatic parse_item_t rand_item(input logic [1:0] req, input logic sbit);
        parse_item_t it;
        begin
            it.req  = req;
            it.sbit = sbit;
            it.qg   = 3'($urandom_range(0, 7));
            it.qb   = 6'($urandom_range(0, 63));
            return it;
        end
    endfunction

    task automatic predict_parse_step(input parse_item_t it, output bit has,
                                      output parse_record_t rec);
        int  glim;
        int  w;
        int  esc;
        int  val;
        int  end_b;
        int  b;
        bit  done;
        bit  last;
        begin
            has  = 1'b0;
            rec  = '0;
            glim = (int'(reg_groups) > GROUPS_N) ? GROUPS_N : int'(reg_groups);
            case (it.req)
                aacsdp_pkg::REQ_START:
                begin
                    work_items++;
                    foreach (band_cb[i])
                    begin
                        band_cb[i] = '0;
                    end
                    cur_grp    = 0;
                    band_pos   = 0;
                    sec_cnt    = 0;
                    shift_bits = 0;
                    taken_bits = 0;
                    held_cb    = '0;
                    len_sum    = 0;
                    if (reg_bands == 6'd0 || glim == 0)
                    begin
                        phase    = PH_IDLE;
                        has      = 1'b1;
                        rec.kind = aacsdp_pkg::KIND_FINISH;
                    end
                    else
                    begin
                        phase = PH_CODEBOOK;
                    end
                end
                aacsdp_pkg::REQ_QUERY:
                begin
                    work_items++;
                    has            = 1'b1;
                    rec.kind       = aacsdp_pkg::KIND_QUERY;
                    rec.group_idx  = it.qg;
                    rec.start_band = it.qb;
                    rec = with_codebook(rec, band_cb[int'(it.qg) * BANDS_N + int'(it.qb)]);
                end
                aacsdp_pkg::REQ_BIT:
                begin
                    if (phase != PH_IDLE)
                    begin
                        work_items++;
                        shift_bits = ((shift_bits << 1) | int'(it.sbit)) & 31;
                        taken_bits = (taken_bits + 1) & 7;
                        if (phase == PH_CODEBOOK)
                        begin
                            if (taken_bits >= aacsdp_pkg::CB_W)
                            begin
                                held_cb    = shift_bits[3:0];
                                shift_bits = 0;
                                taken_bits = 0;
                                len_sum    = 0;
                                phase      = PH_LENGTH;
                            end
                        end
                        else
                        begin
                            w   = reg_short ? aacsdp_pkg::LEN_W_SHORT : aacsdp_pkg::LEN_W_LONG;
                            esc = (1 << w) - 1;
                            if (taken_bits >= w)
                            begin
                                val     = shift_bits & esc;
                                len_sum = len_sum + val;
                                if (len_sum > int'(aacsdp_pkg::LEN_SUM_MAX))
                                begin
                                    len_sum = int'(aacsdp_pkg::LEN_SUM_MAX);
                                end
                                shift_bits = 0;
                                taken_bits = 0;
                                // an all-ones length escapes to another field
                                if (val != esc)
                                begin
                                    end_b = band_pos + len_sum;
                                    if (end_b > BANDS_N)
                                    begin
                                        end_b        = BANDS_N;
                                        rec.overflow = 1'b1;
                                    end
                                    for (b = band_pos; b < end_b; b++)
                                    begin
                                        band_cb[cur_grp * BANDS_N + b] = held_cb;
                                    end
                                    rec.start_band = 6'(band_pos);
                                    rec.end_band   = 7'(end_b);
                                    band_pos       = end_b;
                                    if (sec_cnt < int'(aacsdp_pkg::SEC_CNT_MAX))
                                    begin
                                        sec_cnt++;
                                    end
                                    done = (band_pos >= int'(reg_bands));
                                    last = done && (cur_grp + 1 >= glim);
                                    has               = 1'b1;
                                    rec.kind          = last ? aacsdp_pkg::KIND_FINISH
                                                             : aacsdp_pkg::KIND_SECTION;
                                    rec.group_idx     = 3'(cur_grp);
                                    rec.section_idx   = 6'(sec_cnt - 1);
                                    rec               = with_codebook(rec, held_cb);
                                    rec.group_done    = done;
                                    rec.section_count = done ? 7'(sec_cnt) : 7'd0;
                                    len_sum           = 0;
                                    if (last)
                                    begin
                                        phase = PH_IDLE;
                                    end
                                    else
                                    begin
                                        if (done)
                                        begin
                                            cur_grp  = (cur_grp + 1) & 7;
                                            band_pos = 0;
                                            sec_cnt  = 0;
                                        end
                                        phase = PH_CODEBOOK;
                                    end
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    endtask

    task automatic send_beat(input parse_item_t it, input logic fixed,
                             input logic fixed_has, input parse_record_t fixed_rec);
        int            gap;
        bit            has;
        parse_record_t rec;
        begin
            gap = calm_tx ? 0 : int'($urandom_range(0, 5));
            @(negedge clk);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {6'b0, it.qb, it.qg, it.sbit};
            s_tuser  <= it.req;
            do @(posedge clk); while (s_tready !== 1'b1);
            predict_parse_step(it, has, rec);
            if (fixed)
            begin
                has = fixed_has;
                rec = fixed_rec;
            end
            if (has)
            begin
                pending_records.push_back(rec);
            end
        end
    endtask

    task automatic hold_sender();
        @(negedge clk) s_tvalid <= 1'b0;
    endtask

    // empty the result queue, then give the table engine time to finish
    task automatic quiesce();
        hold_sender();
        while (pending_records.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic sw, input logic [3:0] wg, input logic [5:0] mb);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= aacsdp_pkg::CFG_SHORT_WINDOWS;
        cfg_data  <= {5'b0, sw};
        @(negedge clk);
        cfg_index <= aacsdp_pkg::CFG_WINDOW_GROUPS;
        cfg_data  <= {2'b0, wg};
        @(negedge clk);
        cfg_index <= aacsdp_pkg::CFG_MAX_BANDS;
        cfg_data  <= mb;
        @(negedge clk);
        cfg_we    <= 1'b0;
        reg_short  = sw;
        reg_groups = wg;
        reg_bands  = mb;
    endtask

    task automatic push_bits(input int value, input int width);
        int i;
        begin
            for (i = width - 1; i >= 0; i--)
            begin
                stim_q.push_back(rand_item(aacsdp_pkg::REQ_BIT, 1'((value >> i) & 1)));
            end
        end
    endtask

    // one well-formed parse at the current settings, with queries and noise
    // mixed in, sometimes cut short so that the next start restarts it
    task automatic build_parse();
        int glim;
        int g;
        int pos;
        int rem;
        int len;
        int r;
        int w;
        int esc;
        int k;
        int cut;
        begin
            stim_q.delete();
            stim_q.push_back(rand_item(aacsdp_pkg::REQ_START, 1'($urandom_range(0, 1))));
            glim = (int'(reg_groups) > GROUPS_N) ? GROUPS_N : int'(reg_groups);
            w    = reg_short ? aacsdp_pkg::LEN_W_SHORT : aacsdp_pkg::LEN_W_LONG;
            esc  = (1 << w) - 1;
            for (g = 0; g < glim && reg_bands != 6'd0; g++)
            begin
                pos = 0;
                while (pos < int'(reg_bands))
                begin
                    push_bits(int'($urandom_range(0, 15)), aacsdp_pkg::CB_W);
                    rem = int'(reg_bands) - pos;
                    r   = int'($urandom_range(0, 19));
                    if (r == 0)
                    begin
                        len = 0;
                    end
                    else if (r == 1)
                    begin
                        len = int'($urandom_range(60, 140));
                    end
                    else if (r == 2)
                    begin
                        len = rem + int'($urandom_range(0, 3));
                    end
                    else
                    begin
                        len = int'($urandom_range(1, (rem < 24) ? rem : 24));
                    end
                    pos = pos + ((len > int'(aacsdp_pkg::LEN_SUM_MAX))
                                 ? int'(aacsdp_pkg::LEN_SUM_MAX) : len);
                    if (pos > BANDS_N)
                    begin
                        pos = BANDS_N;
                    end
                    while (len >= esc)
                    begin
                        push_bits(esc, w);
                        len = len - esc;
                    end
                    push_bits(len, w);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        stim_q.push_back(rand_item(aacsdp_pkg::REQ_QUERY,
                                                   1'($urandom_range(0, 1))));
                    end
                    if ($urandom_range(0, 29) == 0)
                    begin
                        stim_q.push_back(rand_item(REQ_UNUSED, 1'($urandom_range(0, 1))));
                    end
                end
            end
            k = int'($urandom_range(0, 3));
            repeat (k) stim_q.push_back(rand_item(aacsdp_pkg::REQ_BIT,
                                                  1'($urandom_range(0, 1))));
            stim_q.push_back(rand_item(aacsdp_pkg::REQ_QUERY, 1'($urandom_range(0, 1))));
            if ($urandom_range(0, 7) == 0 && stim_q.size() > 2)
            begin
                cut = int'($urandom_range(1, stim_q.size() - 1));
                while (stim_q.size() > cut) void'(stim_q.pop_back());
            end
        end
    endtask

    initial
    begin : result_monitor
        int            gap;
        parse_record_t got;
        parse_record_t want;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = calm_rx ? 0 : int'($urandom_range(0, 5));
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            got.kind          = m_tuser;
            got.group_idx     = m_tdata[2:0];
            got.section_idx   = m_tdata[8:3];
            got.codebook      = m_tdata[12:9];
            got.start_band    = m_tdata[18:13];
            got.end_band      = m_tdata[25:19];
            got.int_sign      = m_tdata[27:26];
            got.noise         = m_tdata[28];
            got.group_done    = m_tlast;
            got.section_count = m_tdata[35:29];
            got.overflow      = m_tdata[36];
            if (pending_records.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("unexpected result beat: kind %0d group %0d start %0d",
                             got.kind, got.group_idx, got.start_band);
                end
            end
            else
            begin
                want = pending_records.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch (expected/actual): kind %0d/%0d group %0d/%0d",
                                 want.kind, got.kind, want.group_idx, got.group_idx);
                        $display("  section %0d/%0d codebook %0d/%0d start %0d/%0d end %0d/%0d",
                                 want.section_idx, got.section_idx, want.codebook,
                                 got.codebook, want.start_band, got.start_band,
                                 want.end_band, got.end_band);
                        $display("  sign %0d/%0d noise %0d/%0d done %0d/%0d count %0d/%0d",
                                 want.int_sign, got.int_sign, want.noise, got.noise,
                                 want.group_done, got.group_done, want.section_count,
                                 got.section_count);
                        $display("  overflow %0d/%0d", want.overflow, got.overflow);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        int r;
        int i;
        logic [3:0] wg;
        logic [5:0] mb;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = aacsdp_pkg::CFG_SHORT_WINDOWS;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = aacsdp_pkg::REQ_BIT;
        work_items  = 0;
        calm_tx     = 1'b0;
        calm_rx     = 1'b0;
        reg_short   = 1'b0;
        reg_groups  = 4'd1;
        reg_bands   = 6'd0;
        phase       = PH_IDLE;
        cur_grp     = 0;
        band_pos    = 0;
        sec_cnt     = 0;
        shift_bits  = 0;
        taken_bits  = 0;
        held_cb     = '0;
        len_sum     = 0;
        foreach (band_cb[k])
        begin
            band_cb[k] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (i == DIR_SPLIT)
            begin
                quiesce();
                write_regs(1'b1, 4'd2, 6'd1);
            end
            send_beat(DIR_TAB[i].item, DIR_TAB[i].fixed, DIR_TAB[i].fixed_has,
                      DIR_TAB[i].fixed_rec);
        end

        work_items = 0;
        while (work_items < RANDOM_ITEMS)
        begin
            quiesce();
            r = int'($urandom_range(0, 19));
            case (r)
                0:       wg = 4'd0;
                1:       wg = 4'd15;
                2:       wg = 4'd9;
                3, 4:    wg = 4'd8;
                default: wg = 4'($urandom_range(1, 8));
            endcase
            r = int'($urandom_range(0, 19));
            if (r < 2)
            begin
                mb = 6'd0;
            end
            else if (r < 5)
            begin
                mb = 6'd63;
            end
            else if (r < 8)
            begin
                mb = 6'($urandom_range(17, 62));
            end
            else
            begin
                mb = 6'($urandom_range(1, 16));
            end
            write_regs(1'($urandom_range(0, 1)), wg, mb);
            calm_tx = ($urandom_range(0, 3) == 0);
            calm_rx = ($urandom_range(0, 3) == 0);
            build_parse();
            foreach (stim_q[j])
            begin
                if ($urandom_range(0, 149) == 0)
                begin
                    hold_sender();
                    while (pending_records.size() != 0) @(posedge clk);
                end
                send_beat(stim_q[j], 1'b0, 1'b0, REC_NONE);
            end
        end

        quiesce();
        if (mismatches == 0 && pending_records.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
